FILE: rtl/utf8ae_pkg.sv
// shared types and codes for the utf-8 / escape sequence segmenter
package utf8ae_pkg;

  localparam int unsigned ValueW = 22;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] CHR_N     = 8'h4E;
  localparam logic [7:0] CHR_O     = 8'h4F;
  localparam logic [7:0] CHR_P     = 8'h50;
  localparam logic [7:0] CHR_Q     = 8'h51;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_X     = 8'h58;
  localparam logic [7:0] CHR_LBRK  = 8'h5B;
  localparam logic [7:0] CHR_BSL   = 8'h5C;
  localparam logic [7:0] CHR_RBRK  = 8'h5D;
  localparam logic [7:0] CHR_CARET = 8'h5E;
  localparam logic [7:0] CHR_UNDER = 8'h5F;

  localparam logic [3:0] KIND_CONTROL = 4'd0;
  localparam logic [3:0] KIND_UTF1    = 4'd1;
  localparam logic [3:0] KIND_ESC2    = 4'd5;
  localparam logic [3:0] KIND_SHIFT   = 4'd6;
  localparam logic [3:0] KIND_STRING  = 4'd7;
  localparam logic [3:0] KIND_SOS     = 4'd8;
  localparam logic [3:0] KIND_CSI     = 4'd9;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UTF8     = 2'd1;
  localparam logic [1:0] ERR_PRIVATE  = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b0000001,
    MODE_UTF   = 7'b0000010,
    MODE_ESC   = 7'b0000100,
    MODE_SHIFT = 7'b0001000,
    MODE_STR   = 7'b0010000,
    MODE_SOS   = 7'b0100000,
    MODE_CSI   = 7'b1000000
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [1:0]         remaining;
    logic [ValueW-1:0]  value;
    logic [2:0]         seq_len;
    logic               after_esc;
  } ctx_t;

  localparam ctx_t CTX_IDLE = '{
    mode:      MODE_IDLE,
    remaining: 2'd0,
    value:     '0,
    seq_len:   3'd0,
    after_esc: 1'b0
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       segment_end;
    logic [3:0] segment_kind;
    logic [1:0] error_code;
  } out_word_t;

endpackage

FILE: rtl/utf8ae_step.sv
// one-byte parse step: next parser context and the result word
module utf8ae_step (
  input  utf8ae_pkg::ctx_t      ctx_i,
  input  utf8ae_pkg::in_word_t  word_i,
  output utf8ae_pkg::ctx_t      ctx_o,
  output utf8ae_pkg::out_word_t word_o
);

  logic [7:0]                    b;
  logic                          eot;
  logic                          seg_end;
  logic [3:0]                    kind;
  logic [1:0]                    err;
  logic [1:0]                    rem_dec;
  logic [utf8ae_pkg::ValueW-1:0] cont_value;
  logic                          value_ok;
  logic                          str_term;
  utf8ae_pkg::ctx_t              nxt;

  assign b          = word_i.in_byte;
  assign eot        = word_i.end_of_text;
  assign rem_dec    = ctx_i.remaining - 2'd1;
  assign cont_value = {ctx_i.value[utf8ae_pkg::ValueW-7:0], b[5:0]};

  // string commands stop on anything outside backspace..cr and space..del
  assign str_term = !((b >= 8'h08 && b <= 8'h0D) || (b >= 8'h20 && b <= 8'h7F));

  always_comb begin
    unique case (ctx_i.seq_len)
      3'd2:    value_ok = cont_value >= 22'h80;
      3'd3:    value_ok = cont_value >= 22'h800 &&
                          !(cont_value >= 22'hD800 && cont_value <= 22'hDFFF);
      default: value_ok = cont_value >= 22'h10000 && cont_value < 22'h10FFFE;
    endcase
  end

  always_comb begin
    nxt     = ctx_i;
    seg_end = 1'b0;
    kind    = utf8ae_pkg::KIND_CONTROL;
    err     = utf8ae_pkg::ERR_NONE;
    unique case (ctx_i.mode)
      utf8ae_pkg::MODE_IDLE: begin
        priority if (b == utf8ae_pkg::ESC_BYTE) begin
          if (eot) begin
            seg_end = 1'b1;
            err     = utf8ae_pkg::ERR_TRUNC;
          end else begin
            nxt.mode = utf8ae_pkg::MODE_ESC;
          end
        end else if (b < 8'h20) begin
          seg_end = 1'b1;
        end else if (b < 8'h80) begin
          seg_end = 1'b1;
          kind    = utf8ae_pkg::KIND_UTF1;
        end else if (b < 8'hC2) begin
          seg_end = 1'b1;
          err     = utf8ae_pkg::ERR_UTF8;
        end else begin
          priority if (b < 8'hE0) begin
            nxt.seq_len   = 3'd2;
            nxt.remaining = 2'd1;
            nxt.value     = {{(utf8ae_pkg::ValueW-5){1'b0}}, b[4:0]};
          end else if (b < 8'hF0) begin
            nxt.seq_len   = 3'd3;
            nxt.remaining = 2'd2;
            nxt.value     = {{(utf8ae_pkg::ValueW-4){1'b0}}, b[3:0]};
          end else begin
            nxt.seq_len   = 3'd4;
            nxt.remaining = 2'd3;
            nxt.value     = {{(utf8ae_pkg::ValueW-4){1'b0}}, b[3:0]};
          end
          if (eot) begin
            seg_end = 1'b1;
            err     = utf8ae_pkg::ERR_TRUNC;
          end else begin
            nxt.mode = utf8ae_pkg::MODE_UTF;
          end
        end
      end
      utf8ae_pkg::MODE_UTF: begin
        if (b[7:6] != 2'b10) begin
          seg_end = 1'b1;
          err     = utf8ae_pkg::ERR_UTF8;
        end else begin
          nxt.value     = cont_value;
          nxt.remaining = rem_dec;
          if (rem_dec == 2'd0) begin
            seg_end = 1'b1;
            if (value_ok) kind = {1'b0, ctx_i.seq_len};
            else          err  = utf8ae_pkg::ERR_UTF8;
          end else if (eot) begin
            seg_end = 1'b1;
            err     = utf8ae_pkg::ERR_TRUNC;
          end
        end
      end
      utf8ae_pkg::MODE_ESC: begin
        priority if (b == utf8ae_pkg::CHR_N || b == utf8ae_pkg::CHR_O) begin
          if (eot) begin
            seg_end = 1'b1;
            err     = utf8ae_pkg::ERR_TRUNC;
          end else begin
            nxt.mode = utf8ae_pkg::MODE_SHIFT;
          end
        end else if (b == utf8ae_pkg::CHR_Q || b == utf8ae_pkg::CHR_R) begin
          seg_end = 1'b1;
          err     = utf8ae_pkg::ERR_PRIVATE;
        end else if (b == utf8ae_pkg::CHR_P || b == utf8ae_pkg::CHR_RBRK ||
                     b == utf8ae_pkg::CHR_CARET || b == utf8ae_pkg::CHR_UNDER) begin
          nxt.mode = utf8ae_pkg::MODE_STR;
          seg_end  = eot;
          kind     = utf8ae_pkg::KIND_STRING;
        end else if (b == utf8ae_pkg::CHR_X) begin
          nxt.mode      = utf8ae_pkg::MODE_SOS;
          nxt.after_esc = 1'b0;
          seg_end       = eot;
          kind          = utf8ae_pkg::KIND_SOS;
        end else if (b == utf8ae_pkg::CHR_LBRK) begin
          nxt.mode = utf8ae_pkg::MODE_CSI;
          seg_end  = eot;
          kind     = utf8ae_pkg::KIND_CSI;
        end else begin
          seg_end = 1'b1;
          kind    = utf8ae_pkg::KIND_ESC2;
        end
      end
      utf8ae_pkg::MODE_SHIFT: begin
        seg_end = 1'b1;
        kind    = utf8ae_pkg::KIND_SHIFT;
      end
      utf8ae_pkg::MODE_STR: begin
        seg_end = eot || str_term;
        kind    = utf8ae_pkg::KIND_STRING;
      end
      utf8ae_pkg::MODE_SOS: begin
        // closes on esc x, esc backslash or end of text
        if (eot || (ctx_i.after_esc &&
                    (b == utf8ae_pkg::CHR_X || b == utf8ae_pkg::CHR_BSL))) begin
          seg_end = 1'b1;
          kind    = utf8ae_pkg::KIND_SOS;
        end else begin
          nxt.after_esc = (b == utf8ae_pkg::ESC_BYTE);
        end
      end
      utf8ae_pkg::MODE_CSI: begin
        seg_end = eot || (b >= 8'h40 && b <= 8'h7E);
        kind    = utf8ae_pkg::KIND_CSI;
      end
      default: begin
        seg_end = 1'b1;
        err     = utf8ae_pkg::ERR_UTF8;
      end
    endcase

    // kind only means something on a clean segment end
    if (!seg_end || err != utf8ae_pkg::ERR_NONE) kind = utf8ae_pkg::KIND_CONTROL;
    if (seg_end) nxt = utf8ae_pkg::CTX_IDLE;
  end

  assign ctx_o               = nxt;
  assign word_o.out_byte     = b;
  assign word_o.segment_end  = seg_end;
  assign word_o.segment_kind = kind;
  assign word_o.error_code   = err;

endmodule

FILE: rtl/utf8_ansi_escape_segmenter.sv
// top level: input register, parser context, parse step and result register
//
// Segments a terminal byte stream into control bytes, utf-8 characters and
// esc sequences. Each input word (in_word: in_byte, end_of_text) yields
// exactly one output word echoing the byte, with segment_end set on the byte
// that closes a segment, plus its kind and any error code.
// Both channels use valid/stall: a word moves on a rising edge where valid
// is high and stall is low.
// The accepting edge loads the input register; the parse step then writes the
// result register and the parser context together on an edge where the result
// register is free or out_stall is low, and out_valid rises with it. Throughput
// is one word per cycle while out_stall is low; the only loop is the context
// update through the parse step.
// When out_stall holds a result, one further word is taken into the input
// register; in_stall rises only once both registers are full.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle between segments.
module utf8_ansi_escape_segmenter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  utf8ae_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output utf8ae_pkg::out_word_t out_word
);

  logic                  in_valid_r, in_valid_nxt;
  utf8ae_pkg::in_word_t  in_word_r;
  logic                  out_valid_r, out_valid_nxt;
  utf8ae_pkg::out_word_t out_word_r;
  utf8ae_pkg::ctx_t      ctx_r, ctx_nxt;
  utf8ae_pkg::out_word_t step_word;
  logic                  load_out;
  logic                  advance;
  logic                  accept;

  utf8ae_step u_step (
    .ctx_i  (ctx_r),
    .word_i (in_word_r),
    .ctx_o  (ctx_nxt),
    .word_o (step_word)
  );

  assign load_out = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && load_out;
  assign in_stall = in_valid_r && !load_out;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (advance) in_valid_nxt = 1'b0;
    if (accept)  in_valid_nxt = 1'b1;
    out_valid_nxt = load_out ? in_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r       <= utf8ae_pkg::CTX_IDLE;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)  in_word_r  <= in_word;
    if (advance) out_word_r <= step_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_err_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.error_code != utf8ae_pkg::ERR_NONE
      |-> out_word_r.segment_end && out_word_r.segment_kind == utf8ae_pkg::KIND_CONTROL)
    else $error("error word without clean segment end");

  a_open_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.segment_end
      |-> out_word_r.error_code == utf8ae_pkg::ERR_NONE &&
          out_word_r.segment_kind == utf8ae_pkg::KIND_CONTROL)
    else $error("open segment word carries kind or error");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_word.segment_end |=> ctx_r.mode == utf8ae_pkg::MODE_IDLE)
    else $error("parser not idle after segment end");

  a_utf_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.mode == utf8ae_pkg::MODE_UTF |-> ctx_r.remaining != 2'd0)
    else $error("utf-8 mode with no bytes remaining");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_word_r))
    else $error("held input word lost");

endmodule
